>>> sv/jhsg_pkg.sv
// Shared constants and types for the jog and home setpoint generator.
package jhsg_pkg;

	typedef logic [1:0] op_t;
	typedef logic [2:0] cfg_idx_t;

	localparam op_t OP_DIR  = 2'd0;
	localparam op_t OP_BTN  = 2'd1;
	localparam op_t OP_TICK = 2'd2;

	localparam cfg_idx_t CFG_ROT_COS   = 3'd0;
	localparam cfg_idx_t CFG_ROT_SIN   = 3'd1;
	localparam cfg_idx_t CFG_JOG_LIMIT = 3'd2;
	localparam cfg_idx_t CFG_JOG_GAIN  = 3'd3;
	localparam cfg_idx_t CFG_HOME_Z    = 3'd4;

	localparam int CFG_W  = 16;
	localparam int PEND_W = 18;
	localparam int POS_W  = 32;
	localparam int CNT_W  = 8;

	typedef logic signed [PEND_W-1:0] pend_t;
	typedef logic signed [POS_W-1:0]  pos_t;

	localparam logic [CNT_W-1:0] HOMING_STEPS = 8'd120;

	// Division by 120 is done as a shift by 3 followed by a multiply with the
	// rounded-up reciprocal of 15 scaled by 2^34, exact for dividends below 2^30.
	localparam int HOME_DIV_PRE = 3;
	localparam int HOME_DIV_RSH = 34;
	localparam logic [30:0] HOME_DIV_MUL = 31'd1145324613;

	localparam logic signed [15:0] ROT_COS_RST   = 16'sd9397;
	localparam logic signed [15:0] ROT_SIN_RST   = 16'sd13421;
	localparam logic [14:0]        JOG_LIMIT_RST = 15'd3277;
	localparam logic [7:0]         JOG_GAIN_RST  = 8'd10;
	localparam logic [9:0]         HOME_Z_RST    = 10'd300;

	localparam pos_t CUR_Z_RST = pos_t'({HOME_Z_RST, 16'h0000});

endpackage

>>> sv/jhsg_rot.sv
// Rotation of a direction word into the pending jog increments.
module jhsg_rot import jhsg_pkg::*; (
	input  logic signed [15:0] rot_cos,
	input  logic signed [15:0] rot_sin,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	output pend_t              pend_x,
	output pend_t              pend_y
);

	logic signed [31:0] cx;
	logic signed [31:0] sy;
	logic signed [31:0] sx;
	logic signed [31:0] cy;
	logic signed [33:0] sum_x;
	logic signed [33:0] sum_y;
	logic signed [19:0] sh_x;
	logic signed [19:0] sh_y;

	function automatic pend_t sat_pend(input logic signed [19:0] v);
		pend_t r;
		if (v > 20'sd131071) begin
			r = 18'sd131071;
		end else if (v < -20'sd131072) begin
			r = -18'sd131072;
		end else begin
			r = v[PEND_W-1:0];
		end
		return r;
	endfunction

	assign cx = 32'(rot_cos) * 32'(dir_x);
	assign sy = 32'(rot_sin) * 32'(dir_y);
	assign sx = 32'(rot_sin) * 32'(dir_x);
	assign cy = 32'(rot_cos) * 32'(dir_y);

	assign sum_x = 34'(cx) - 34'(sy);
	assign sum_y = -34'(sx) - 34'(cy);

	// The values never exceed 2^32 in magnitude, so 20 bits hold the shifted sum.
	assign sh_x = 20'(sum_x >>> 14);
	assign sh_y = 20'(sum_y >>> 14);

	assign pend_x = sat_pend(sh_x);
	assign pend_y = sat_pend(sh_y);

endmodule

>>> sv/jhsg_step.sv
// Per-axis homing step: distance to home divided by the homing step count.
module jhsg_step import jhsg_pkg::*; (
	input  pos_t       cur_x,
	input  pos_t       cur_y,
	input  pos_t       cur_z,
	input  logic [9:0] home_z,
	output pos_t       step_x,
	output pos_t       step_y,
	output pos_t       step_z
);

	logic signed [32:0] diff_x;
	logic signed [32:0] diff_y;
	logic signed [32:0] diff_z;

	// Truncates toward zero; the quotient always fits in 32 bits.
	function automatic pos_t div_home(input logic signed [32:0] d);
		logic        neg;
		logic [32:0] mag;
		logic [29:0] n;
		logic [60:0] prod;
		logic [26:0] q;
		pos_t        r;
		neg  = d[32];
		mag  = neg ? 33'(-d) : 33'(d);
		n    = mag[32:HOME_DIV_PRE];
		prod = 61'(n) * 61'(HOME_DIV_MUL);
		q    = prod[60:HOME_DIV_RSH];
		r    = neg ? -pos_t'({5'b0, q}) : pos_t'({5'b0, q});
		return r;
	endfunction

	assign diff_x = 33'sd0 - 33'(cur_x);
	assign diff_y = 33'sd0 - 33'(cur_y);
	assign diff_z = $signed({7'b0, home_z, 16'h0000}) - 33'(cur_z);

	assign step_x = div_home(diff_x);
	assign step_y = div_home(diff_y);
	assign step_z = div_home(diff_z);

endmodule

>>> sv/jog_and_home_setpoint_generator.sv
// Top level of the jog and home setpoint generator.
//
// The input channel (in_valid, in_stall) carries one word per operation:
// a direction update (op, dir_x, dir_y), a button event (pressed) or a
// control tick. Only a control tick produces an output word (pos_x, pos_y,
// pos_z, homing) on the output channel (out_valid, out_stall), which holds
// the setpoint after that tick.
// A word is registered at acceptance and processed when the output register
// is empty or being read, so a tick result then goes into the output register.
// One word is accepted every cycle while in_stall is low; the state update is
// a single pass of logic between the input register and state and result registers.
// While the receiver stalls with a result pending, the registered word that
// waits behind it holds, and in_stall rises once that word is present.
// Reset loads the default register values, puts the block in jog mode with
// the setpoint at x = 0, y = 0 and z at the default home height, and clears
// the pending increments, steps and the step count.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at
// the next clock edge and are meant for times when the block is idle.
module jog_and_home_setpoint_generator import jhsg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  cfg_idx_t          cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  op_t               op,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic              pressed,
	output logic              out_valid,
	input  logic              out_stall,
	output pos_t              pos_x,
	output pos_t              pos_y,
	output pos_t              pos_z,
	output logic              homing
);

	logic signed [15:0] rot_cos_q;
	logic signed [15:0] rot_sin_q;
	logic [14:0]        jog_limit_q;
	logic [7:0]         jog_gain_q;
	logic [9:0]         home_z_q;

	logic               valid_s1;
	op_t                op_s1;
	logic signed [15:0] dir_x_s1;
	logic signed [15:0] dir_y_s1;
	logic               pressed_s1;

	pos_t             cur_x_q;
	pos_t             cur_y_q;
	pos_t             cur_z_q;
	pend_t            pend_x_q;
	pend_t            pend_y_q;
	pos_t             step_x_q;
	pos_t             step_y_q;
	pos_t             step_z_q;
	logic             home_mode_q;
	logic [CNT_W-1:0] tick_count_q;

	logic             out_valid_q;
	pos_t             pos_x_q;
	pos_t             pos_y_q;
	pos_t             pos_z_q;
	logic             homing_q;

	logic  adv;
	logic  fire;
	logic  in_acc;
	logic  home_run;
	pend_t rot_x;
	pend_t rot_y;
	pos_t  new_step_x;
	pos_t  new_step_y;
	pos_t  new_step_z;
	pos_t  nxt_x;
	pos_t  nxt_y;
	pos_t  nxt_z;

	function automatic pos_t sat32(input logic signed [32:0] v);
		pos_t r;
		if (v[32] != v[31]) begin
			r = v[32] ? pos_t'({1'b1, 31'h0}) : pos_t'({1'b0, {31{1'b1}}});
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Pending increment is clamped from above only, then scaled to Q16.16.
	function automatic pos_t jog_move(input pos_t cur, input pend_t pend,
		input logic [14:0] lim, input logic [7:0] gain);
		pend_t              p;
		logic signed [26:0] prod;
		logic signed [28:0] delta;
		p     = (pend > $signed({3'b000, lim})) ? $signed({3'b000, lim}) : pend;
		prod  = 27'(p) * $signed({19'b0, gain});
		delta = 29'(prod) <<< 2;
		return sat32(33'(cur) + 33'(delta));
	endfunction

	jhsg_rot u_rot (
		.rot_cos (rot_cos_q),
		.rot_sin (rot_sin_q),
		.dir_x   (dir_x_s1),
		.dir_y   (dir_y_s1),
		.pend_x  (rot_x),
		.pend_y  (rot_y)
	);

	jhsg_step u_step (
		.cur_x  (cur_x_q),
		.cur_y  (cur_y_q),
		.cur_z  (cur_z_q),
		.home_z (home_z_q),
		.step_x (new_step_x),
		.step_y (new_step_y),
		.step_z (new_step_z)
	);

	assign adv      = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;
	assign home_run = tick_count_q < HOMING_STEPS;

	always_comb begin
		nxt_x = cur_x_q;
		nxt_y = cur_y_q;
		nxt_z = cur_z_q;
		if (!home_mode_q) begin
			nxt_x = jog_move(cur_x_q, pend_x_q, jog_limit_q, jog_gain_q);
			nxt_y = jog_move(cur_y_q, pend_y_q, jog_limit_q, jog_gain_q);
		end else if (home_run) begin
			nxt_x = sat32(33'(cur_x_q) + 33'(step_x_q));
			nxt_y = sat32(33'(cur_y_q) + 33'(step_y_q));
			nxt_z = sat32(33'(cur_z_q) + 33'(step_z_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_cos_q   <= ROT_COS_RST;
			rot_sin_q   <= ROT_SIN_RST;
			jog_limit_q <= JOG_LIMIT_RST;
			jog_gain_q  <= JOG_GAIN_RST;
			home_z_q    <= HOME_Z_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROT_COS:   rot_cos_q   <= cfg_data;
				CFG_ROT_SIN:   rot_sin_q   <= cfg_data;
				CFG_JOG_LIMIT: jog_limit_q <= cfg_data[14:0];
				CFG_JOG_GAIN:  jog_gain_q  <= cfg_data[7:0];
				CFG_HOME_Z:    home_z_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1      <= op;
			dir_x_s1   <= dir_x;
			dir_y_s1   <= dir_y;
			pressed_s1 <= pressed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			cur_z_q      <= CUR_Z_RST;
			pend_x_q     <= '0;
			pend_y_q     <= '0;
			step_x_q     <= '0;
			step_y_q     <= '0;
			step_z_q     <= '0;
			home_mode_q  <= 1'b0;
			tick_count_q <= '0;
		end else if (fire) begin
			unique case (op_s1)
				OP_DIR: begin
					pend_x_q <= rot_x;
					pend_y_q <= rot_y;
				end
				OP_BTN: begin
					if (pressed_s1) begin
						if (!home_mode_q) begin
							step_x_q     <= new_step_x;
							step_y_q     <= new_step_y;
							step_z_q     <= new_step_z;
							tick_count_q <= '0;
							home_mode_q  <= 1'b1;
						end else begin
							home_mode_q <= 1'b0;
						end
					end
				end
				OP_TICK: begin
					cur_x_q <= nxt_x;
					cur_y_q <= nxt_y;
					cur_z_q <= nxt_z;
					if (!home_mode_q) begin
						pend_x_q <= '0;
						pend_y_q <= '0;
					end else if (home_run) begin
						tick_count_q <= tick_count_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && op_s1 == OP_TICK) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && op_s1 == OP_TICK) begin
			pos_x_q  <= nxt_x;
			pos_y_q  <= nxt_y;
			pos_z_q  <= nxt_z;
			homing_q <= home_mode_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign pos_z     = pos_z_q;
	assign homing    = homing_q;

	// The step count never runs past the number of homing steps.
	assert property (@(posedge clk) disable iff (!arst_n)
		tick_count_q <= HOMING_STEPS)
		else $error("homing step count overran");

	// Every processed tick leaves a result in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_s1 == OP_TICK) |=> out_valid_q)
		else $error("tick produced no result");

	// A jog tick consumes the pending increments.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_s1 == OP_TICK && !home_mode_q) |=>
		(pend_x_q == '0 && pend_y_q == '0))
		else $error("pending increments not cleared after jog tick");

	// Once homing has finished, further ticks leave the setpoint unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_s1 == OP_TICK && home_mode_q && !home_run) |=>
		($stable(cur_x_q) && $stable(cur_y_q) && $stable(cur_z_q)))
		else $error("setpoint moved after homing finished");

	// A word in the input register is never lost while the output is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1)
		else $error("stalled word dropped");

endmodule

>>> tb/sv/setpoint_checker.sv
`timescale 1ns / 100ps
// Checker that predicts each setpoint word of the jog and home generator and compares it.
module setpoint_checker import jhsg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  cfg_idx_t           cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  op_t                op,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic               pressed,
	input  logic               out_valid,
	input  logic               out_stall,
	input  pos_t               pos_x,
	input  pos_t               pos_y,
	input  pos_t               pos_z,
	input  logic               homing,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct packed {
		pos_t x;
		pos_t y;
		pos_t z;
		logic homing;
	} setpoint_t;

	localparam longint POS_MAX    = 64'sd2147483647;
	localparam longint POS_MIN    = -64'sd2147483648;
	localparam longint PEND_MAX   = 64'sd131071;
	localparam longint PEND_MIN   = -64'sd131072;
	localparam longint HOME_TICKS = longint'(HOMING_STEPS);

	logic signed [15:0] rot_cos_q;
	logic signed [15:0] rot_sin_q;
	logic [14:0] jog_limit_q;
	logic [7:0] jog_gain_q;
	logic [9:0] home_z_q;
	pos_t cur_x, cur_y, cur_z;
	pos_t step_x, step_y, step_z;
	pend_t pend_x, pend_y;
	logic homing_mode;
	logic [CNT_W-1:0] homing_ticks;
	setpoint_t expected_setpoints[$];

	function automatic pos_t clamp_pos(input longint v);
		if (v > POS_MAX) return pos_t'(POS_MAX);
		if (v < POS_MIN) return pos_t'(POS_MIN);
		return pos_t'(v);
	endfunction

	function automatic pend_t clamp_pend(input longint v);
		if (v > PEND_MAX) return pend_t'(PEND_MAX);
		if (v < PEND_MIN) return pend_t'(PEND_MIN);
		return pend_t'(v);
	endfunction

	// Increments are clamped from above only; a negative one passes unchanged.
	function automatic pos_t jog_move(input pos_t cur, input pend_t pend);
		longint inc;
		inc = longint'(pend);
		if (inc > longint'(jog_limit_q))
			inc = longint'(jog_limit_q);
		return clamp_pos(longint'(cur) + inc * longint'(jog_gain_q) * 4);
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict
		setpoint_t got, want;
		longint sum_x, sum_y, home_height;
		if (!arst_n) begin
			rot_cos_q = ROT_COS_RST;
			rot_sin_q = ROT_SIN_RST;
			jog_limit_q = JOG_LIMIT_RST;
			jog_gain_q = JOG_GAIN_RST;
			home_z_q = HOME_Z_RST;
			cur_x = '0;
			cur_y = '0;
			cur_z = CUR_Z_RST;
			step_x = '0;
			step_y = '0;
			step_z = '0;
			pend_x = '0;
			pend_y = '0;
			homing_mode = 1'b0;
			homing_ticks = '0;
			expected_setpoints.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROT_COS: rot_cos_q = cfg_data;
					CFG_ROT_SIN: rot_sin_q = cfg_data;
					CFG_JOG_LIMIT: jog_limit_q = cfg_data[14:0];
					CFG_JOG_GAIN: jog_gain_q = cfg_data[7:0];
					CFG_HOME_Z: home_z_q = cfg_data[9:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				got = '{pos_x, pos_y, pos_z, homing};
				if (expected_setpoints.size() == 0) begin
					if (mismatches < 10)
						$display("Unexpected setpoint word: x=%0d y=%0d z=%0d homing=%0b",
							got.x, got.y, got.z, got.homing);
					mismatches++;
				end else begin
					want = expected_setpoints.pop_front();
					if (got != want) begin
						if (mismatches < 10) begin
							$write("Setpoint mismatch: expected x=%0d y=%0d z=%0d homing=%0b,",
								want.x, want.y, want.z, want.homing);
							$display(" got x=%0d y=%0d z=%0d homing=%0b",
								got.x, got.y, got.z, got.homing);
						end
						mismatches++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				case (op)
					OP_DIR: begin
						sum_x = longint'(rot_cos_q) * longint'(dir_x)
							- longint'(rot_sin_q) * longint'(dir_y);
						sum_y = -longint'(rot_sin_q) * longint'(dir_x)
							- longint'(rot_cos_q) * longint'(dir_y);
						pend_x = clamp_pend(sum_x >>> 14);
						pend_y = clamp_pend(sum_y >>> 14);
					end
					OP_BTN: begin
						if (pressed && !homing_mode) begin
							home_height = longint'(home_z_q) * 65536;
							step_x = clamp_pos((0 - longint'(cur_x)) / HOME_TICKS);
							step_y = clamp_pos((0 - longint'(cur_y)) / HOME_TICKS);
							step_z = clamp_pos((home_height - longint'(cur_z)) / HOME_TICKS);
							homing_ticks = '0;
							homing_mode = 1'b1;
						end else if (pressed) begin
							homing_mode = 1'b0;
						end
					end
					OP_TICK: begin
						if (!homing_mode) begin
							cur_x = jog_move(cur_x, pend_x);
							cur_y = jog_move(cur_y, pend_y);
							pend_x = '0;
							pend_y = '0;
						end else if (homing_ticks < HOMING_STEPS) begin
							cur_x = clamp_pos(longint'(cur_x) + longint'(step_x));
							cur_y = clamp_pos(longint'(cur_y) + longint'(step_y));
							cur_z = clamp_pos(longint'(cur_z) + longint'(step_z));
							homing_ticks++;
						end
						expected_setpoints.push_back('{cur_x, cur_y, cur_z, homing_mode});
					end
					default: ;
				endcase
			end
			outstanding = expected_setpoints.size();
		end
	end

endmodule

>>> tb/sv/tb_jog_and_home_setpoint_generator.sv
`timescale 1ns / 100ps
// Testbench top for the jog and home setpoint generator: stimulus, idling and verdict.
module tb_jog_and_home_setpoint_generator;
	import jhsg_pkg::*;

	localparam op_t OP_UNUSED  = 2'd3;
	localparam int PHASE_WORDS = 220;
	localparam int LAST_PHASE  = 6;
	localparam int HOLD_CYCLES = 60;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	op_t op;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic pressed;
	logic out_valid;
	logic out_stall;
	pos_t pos_x, pos_y, pos_z;
	logic homing;
	int mismatches;
	int outstanding;
	int words_sent;
	int phase_words;
	int idle_cycles;
	bit quiet;
	bit hold_req;

	always #10 clk = ~clk;

	jog_and_home_setpoint_generator DUT (.*);

	setpoint_checker u_setpoint_checker (.*);

	task automatic send_word(input op_t code, input logic [15:0] dx, input logic [15:0] dy,
			input logic btn);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		dir_x <= dx;
		dir_y <= dy;
		pressed <= btn;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
		phase_words++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_settings(input int c, input int s, input int lim, input int gain,
			input int hz);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROT_COS;
		cfg_data <= CFG_W'(c);
		@(posedge clk);
		cfg_index <= CFG_ROT_SIN;
		cfg_data <= CFG_W'(s);
		@(posedge clk);
		cfg_index <= CFG_JOG_LIMIT;
		cfg_data <= CFG_W'(lim);
		@(posedge clk);
		cfg_index <= CFG_JOG_GAIN;
		cfg_data <= CFG_W'(gain);
		@(posedge clk);
		cfg_index <= CFG_HOME_Z;
		cfg_data <= CFG_W'(hz);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_dir();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 32768) - 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_episode();
		int kind, n;
		logic [15:0] aim_x, aim_y;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			n = $urandom_range(1, 12);
			repeat (n) begin
				if ($urandom_range(0, 3) != 0)
					send_word(OP_DIR, pick_dir(), pick_dir(), 1'($urandom));
				send_word(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
			end
		end else if (kind < 6) begin
			// A steady push in one direction, long enough to run into saturation.
			aim_x = pick_dir();
			aim_y = pick_dir();
			n = $urandom_range(10, 80);
			repeat (n) begin
				send_word(OP_DIR, aim_x, aim_y, 1'($urandom));
				send_word(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
			end
		end else if (kind < 8) begin
			send_word(OP_BTN, 16'($urandom), 16'($urandom), 1'b1);
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(118, 130) : $urandom_range(1, 20);
			repeat (n) begin
				case ($urandom_range(0, 9))
					0: send_word(OP_DIR, pick_dir(), pick_dir(), 1'($urandom));
					1: send_word(OP_BTN, 16'($urandom), 16'($urandom), 1'b0);
					default: send_word(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
				endcase
			end
			send_word(OP_BTN, 16'($urandom), 16'($urandom), 1'b1);
		end else begin
			n = $urandom_range(1, 8);
			repeat (n)
				send_word(op_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
					1'($urandom));
		end
	endtask

	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin : rx_idle
			int span;
			if (hold_req) begin
				out_stall <= 1'b1;
				span = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
				span = $urandom_range(1, 10);
			end else begin
				out_stall <= 1'b1;
				span = $urandom_range(1, 10);
			end
			repeat (span) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ROT_COS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		op <= OP_DIR;
		dir_x <= '0;
		dir_y <= '0;
		pressed <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);
		send_word(OP_DIR, 16'h7fff, 16'h8000, 1'b0);
		send_word(OP_TICK, 16'hffff, 16'hffff, 1'b1);
		send_word(OP_DIR, 16'h8000, 16'h7fff, 1'b1);
		send_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);
		send_word(OP_DIR, 16'h8000, 16'h8000, 1'b0);
		send_word(OP_TICK, 16'h7fff, 16'h8000, 1'b1);
		send_word(OP_DIR, 16'h7fff, 16'h7fff, 1'b1);
		send_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);
		send_word(OP_BTN, 16'h7fff, 16'h8000, 1'b0);
		send_word(OP_UNUSED, 16'h7fff, 16'h7fff, 1'b1);
		send_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);
		send_word(OP_BTN, 16'h0000, 16'h0000, 1'b1);
		send_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);
		send_word(OP_TICK, 16'hffff, 16'hffff, 1'b1);
		// The increment set during homing must survive until the next jog tick.
		send_word(OP_DIR, 16'h8000, 16'h0001, 1'b0);
		send_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);
		send_word(OP_BTN, 16'h0000, 16'h0000, 1'b1);
		send_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);
		send_word(OP_TICK, 16'h0000, 16'h0000, 1'b0);

		for (int phase = 1; phase <= LAST_PHASE; phase++) begin
			settle();
			case (phase)
				1: write_settings(16384, -16384, 32767, 255, 1023);
				2: write_settings(-16384, 16384, 0, 255, 0);
				3: write_settings(0, 0, 32767, 0, 1023);
				default: write_settings($urandom_range(0, 32768) - 16384,
					$urandom_range(0, 32768) - 16384, $urandom_range(0, 32767),
					$urandom_range(0, 255), $urandom_range(0, 1023));
			endcase
			if (phase == 1)
				hold_req = 1'b1;
			quiet = (phase == LAST_PHASE);
			phase_words = 0;
			while (phase_words < PHASE_WORDS) random_episode();
		end

		settle();
		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
